### rtl/core/sqsab_pkg.sv
// ----------------------------------------------------------------------------
// sqsab_pkg: shared definitions of the sample queue / spread alarm monitor
// Operation codes, register map, microcode format and the microcode program.
// ----------------------------------------------------------------------------
package sqsab_pkg;

  localparam int ValW  = 10;
  localparam int CntW  = 3;
  localparam int TickW = 3;
  localparam int PerW  = 3;

  localparam int STdataW = 16;
  localparam int MTdataW = 40;
  localparam int PaddrW  = 4;
  localparam int PdataW  = 32;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_DRAIN  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD  = 2'd2;
  localparam logic [1:0] REG_SLOW_PER   = 2'd3;

  localparam logic [ValW-1:0]  LOW_LIMIT_RST  = 10'd10;
  localparam logic [ValW-1:0]  HIGH_LIMIT_RST = 10'd1013;
  localparam logic [ValW-1:0]  THRESHOLD_RST  = 10'd500;
  localparam logic [PerW-1:0]  SLOW_PER_RST   = 3'd4;
  localparam logic [ValW-1:0]  VAL_MAX        = 10'd1023;
  localparam logic [TickW-1:0] TICK_MAX       = 3'd7;

  typedef struct packed {
    logic [ValW-1:0] low_limit;
    logic [ValW-1:0] high_limit;
    logic [ValW-1:0] threshold;
    logic [PerW-1:0] slow_period;
  } cfg_t;

  // Datapath action of one microcode step.
  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_CAPTURE,
    ACT_SAMPLE,
    ACT_DRAIN_INIT,
    ACT_DRAIN_STEP,
    ACT_DRAIN_FIN,
    ACT_TICK,
    ACT_EMIT
  } act_e;

  // Sequencing of one microcode step.
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_DISPATCH,
    JMP_NONEMPTY,
    JMP_OUT_FREE
  } jmp_e;

  typedef logic [2:0] step_t;

  localparam step_t STEP_FETCH      = 3'd0;
  localparam step_t STEP_SAMPLE     = 3'd1;
  localparam step_t STEP_DRAIN_INIT = 3'd2;
  localparam step_t STEP_DRAIN_LOOP = 3'd3;
  localparam step_t STEP_DRAIN_FIN  = 3'd4;
  localparam step_t STEP_TICK       = 3'd5;
  localparam step_t STEP_EMIT       = 3'd6;

  typedef struct packed {
    act_e  act;
    jmp_e  jmp;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic       in_fire;
    logic [1:0] op;
    logic       nonempty;
    logic       out_free;
  } dp_status_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{act: ACT_NOP, jmp: JMP_ALWAYS, target: STEP_FETCH};
    unique case (s)
      STEP_FETCH:      w = '{act: ACT_CAPTURE,    jmp: JMP_DISPATCH, target: STEP_FETCH};
      STEP_SAMPLE:     w = '{act: ACT_SAMPLE,     jmp: JMP_ALWAYS,   target: STEP_EMIT};
      STEP_DRAIN_INIT: w = '{act: ACT_DRAIN_INIT, jmp: JMP_NEXT,     target: STEP_FETCH};
      // Pops one entry per pass and loops while the queue still held data.
      STEP_DRAIN_LOOP: w = '{act: ACT_DRAIN_STEP, jmp: JMP_NONEMPTY, target: STEP_DRAIN_LOOP};
      STEP_DRAIN_FIN:  w = '{act: ACT_DRAIN_FIN,  jmp: JMP_ALWAYS,   target: STEP_EMIT};
      STEP_TICK:       w = '{act: ACT_TICK,       jmp: JMP_ALWAYS,   target: STEP_EMIT};
      STEP_EMIT:       w = '{act: ACT_EMIT,       jmp: JMP_OUT_FREE, target: STEP_FETCH};
      default:         w = '{act: ACT_NOP,        jmp: JMP_ALWAYS,   target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/sqsab_seq.sv
// ----------------------------------------------------------------------------
// sqsab_seq: microcode sequencer
// Step counter, program lookup and conditional jumps.
// ----------------------------------------------------------------------------
module sqsab_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sqsab_pkg::dp_status_t  status_i,
  output sqsab_pkg::uword_t      uword_o
);

  sqsab_pkg::step_t  pc_q, pc_d;
  sqsab_pkg::uword_t uw;

  assign uw      = sqsab_pkg::ucode(pc_q);
  assign uword_o = uw;

  always_comb begin
    pc_d = pc_q;
    unique case (uw.jmp)
      sqsab_pkg::JMP_NEXT:   pc_d = pc_q + 3'd1;
      sqsab_pkg::JMP_ALWAYS: pc_d = uw.target;
      sqsab_pkg::JMP_DISPATCH: begin
        if (status_i.in_fire) begin
          case (status_i.op)
            sqsab_pkg::OP_SAMPLE: pc_d = sqsab_pkg::STEP_SAMPLE;
            sqsab_pkg::OP_DRAIN:  pc_d = sqsab_pkg::STEP_DRAIN_INIT;
            sqsab_pkg::OP_TICK:   pc_d = sqsab_pkg::STEP_TICK;
            default:              pc_d = sqsab_pkg::STEP_EMIT;
          endcase
        end
      end
      sqsab_pkg::JMP_NONEMPTY: pc_d = status_i.nonempty ? uw.target : pc_q + 3'd1;
      sqsab_pkg::JMP_OUT_FREE: pc_d = status_i.out_free ? uw.target : pc_q;
      default:                 pc_d = sqsab_pkg::STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= sqsab_pkg::STEP_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/core/sqsab_dp.sv
// ----------------------------------------------------------------------------
// sqsab_dp: monitor datapath
// Sample queue, drain statistics, flags, LED blinker and result register.
// ----------------------------------------------------------------------------
module sqsab_dp #(
  parameter int QUEUE_DEPTH = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sqsab_pkg::uword_t             uword_i,
  input  sqsab_pkg::cfg_t               cfg_i,
  input  logic                          in_fire_i,
  input  logic [sqsab_pkg::STdataW-1:0] in_data_i,
  input  logic                          out_ready_i,
  output sqsab_pkg::dp_status_t         status_o,
  output logic                          out_valid_o,
  output logic [sqsab_pkg::MTdataW-1:0] out_data_o
);

  localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  LastSlot = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FullCnt  = FillW'(QUEUE_DEPTH);

  logic [sqsab_pkg::ValW-1:0] mem_q [QUEUE_DEPTH];

  logic [PtrW-1:0]             wptr_q, rptr_q;
  logic [FillW-1:0]            fill_q;
  logic                        err_q, alarm_q, phase_q, first_q;
  logic [sqsab_pkg::TickW-1:0] tick_q;
  logic [sqsab_pkg::ValW-1:0]  x_q;

  logic                        ovf_q, got_q, lw_q, ll_q;
  logic [sqsab_pkg::CntW-1:0]  cnt_q;
  logic [sqsab_pkg::ValW-1:0]  lo_q, hi_q, spr_q;

  logic                                  out_valid_q;
  logic [sqsab_pkg::MTdataW-1:0]         out_data_q;

  logic                        out_free, emit;
  logic [sqsab_pkg::ValW-1:0]  rd_q, spr_w;
  logic [PtrW-1:0]             rptr_inc, rd_addr;
  logic                        slow_fire;

  assign out_free  = !out_valid_q || out_ready_i;
  assign emit      = (uword_i.act == sqsab_pkg::ACT_EMIT) && out_free;
  assign spr_w     = hi_q - lo_q;
  assign slow_fire = alarm_q && (tick_q >= cfg_i.slow_period);
  assign rptr_inc  = (rptr_q == LastSlot) ? '0 : rptr_q + PtrW'(1);

  // The queue is read ahead: during a pop the entry behind the head
  // is fetched so that the next drain pass finds it in the read register.
  assign rd_addr = ((uword_i.act == sqsab_pkg::ACT_DRAIN_STEP) && (fill_q != '0)) ?
                   rptr_inc : rptr_q;

  assign status_o.in_fire  = in_fire_i;
  assign status_o.op       = in_data_i[1:0];
  assign status_o.nonempty = (fill_q != '0);
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Control state and per-operation result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      rptr_q      <= '0;
      fill_q      <= '0;
      err_q       <= 1'b0;
      alarm_q     <= 1'b0;
      phase_q     <= 1'b0;
      first_q     <= 1'b1;
      tick_q      <= '0;
      ovf_q       <= 1'b0;
      got_q       <= 1'b0;
      lw_q        <= 1'b0;
      ll_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (uword_i.act)
        sqsab_pkg::ACT_CAPTURE: begin
          if (in_fire_i) begin
            ovf_q <= 1'b0;
            got_q <= 1'b0;
            lw_q  <= 1'b0;
            ll_q  <= 1'b0;
            cnt_q <= '0;
          end
        end
        sqsab_pkg::ACT_SAMPLE: begin
          err_q <= (x_q < cfg_i.low_limit) || (x_q > cfg_i.high_limit);
          if (fill_q == FullCnt) begin
            ovf_q <= 1'b1;
          end else begin
            fill_q <= fill_q + FillW'(1);
            wptr_q <= (wptr_q == LastSlot) ? '0 : wptr_q + PtrW'(1);
          end
        end
        sqsab_pkg::ACT_DRAIN_STEP: begin
          if (fill_q != '0) begin
            fill_q <= fill_q - FillW'(1);
            rptr_q <= rptr_inc;
            cnt_q  <= cnt_q + 3'd1;
            got_q  <= 1'b1;
          end
        end
        sqsab_pkg::ACT_DRAIN_FIN: begin
          alarm_q <= got_q && (spr_w > cfg_i.threshold);
        end
        sqsab_pkg::ACT_TICK: begin
          if (err_q) begin
            lw_q    <= 1'b1;
            ll_q    <= phase_q;
            phase_q <= !phase_q;
            first_q <= 1'b1;
          end else if (slow_fire) begin
            // The first slow blink after leaving another mode is lit.
            lw_q    <= 1'b1;
            ll_q    <= first_q | phase_q;
            phase_q <= !(first_q | phase_q);
            first_q <= 1'b0;
          end else if (!alarm_q) begin
            lw_q    <= 1'b1;
            ll_q    <= 1'b0;
            first_q <= 1'b1;
          end
          if (!err_q && slow_fire) begin
            tick_q <= 3'd1;
          end else if (tick_q != sqsab_pkg::TICK_MAX) begin
            tick_q <= tick_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: queue storage, captured reading, statistics and result register.
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    case (uword_i.act)
      sqsab_pkg::ACT_CAPTURE: begin
        if (in_fire_i) begin
          x_q   <= in_data_i[11:2];
          lo_q  <= '0;
          hi_q  <= '0;
          spr_q <= '0;
        end
      end
      sqsab_pkg::ACT_SAMPLE: begin
        if (fill_q != FullCnt) begin
          mem_q[wptr_q] <= x_q;
        end
      end
      sqsab_pkg::ACT_DRAIN_INIT: begin
        lo_q <= sqsab_pkg::VAL_MAX;
        hi_q <= '0;
      end
      sqsab_pkg::ACT_DRAIN_STEP: begin
        if (fill_q != '0) begin
          if (rd_q < lo_q) lo_q <= rd_q;
          if (rd_q > hi_q) hi_q <= rd_q;
        end
      end
      sqsab_pkg::ACT_DRAIN_FIN: begin
        if (got_q) begin
          spr_q <= spr_w;
        end else begin
          lo_q  <= '0;
          hi_q  <= '0;
          spr_q <= '0;
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_data_q <= {2'b00, ll_q, lw_q, spr_q, hi_q, lo_q, cnt_q, alarm_q, err_q, ovf_q};
    end
  end

endmodule

### rtl/core/sample_queue_spread_alarm_blinker_unit.sv
// ----------------------------------------------------------------------------
// sample_queue_spread_alarm_blinker_unit: sensor monitor top level
// Stream in, stream out, APB register file, sequencer and datapath.
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one result transaction. A sample or a
// tick steps through fetch, operate and emit; a drain steps through fetch,
// drain init, the drain loop, drain finish and emit, where the microcode loop
// pops one entry per cycle from the queue and needs one more pass to see it
// empty. An unused operation code goes from fetch straight to emit, and the
// emit step waits while the output register still holds an untaken result.
// The next input is accepted only once the sequencer is back at its fetch
// step, but a finished result may wait in the output register meanwhile.
module sample_queue_spread_alarm_blinker_unit #(
  parameter int QUEUE_DEPTH = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // s_axis_tdata: [1:0] operation, [11:2] sample_value, rest zero.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sqsab_pkg::STdataW-1:0] s_axis_tdata,
  // m_axis_tdata: [0] overflow, [1] error_out, [2] alarm_out,
  // [5:3] drained_count, [15:6] min_value, [25:16] max_value,
  // [35:26] spread, [36] led_write, [37] led_level, rest zero.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sqsab_pkg::MTdataW-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sqsab_pkg::PaddrW-1:0]  paddr,
  input  logic [sqsab_pkg::PdataW-1:0]  pwdata,
  output logic [sqsab_pkg::PdataW-1:0]  prdata,
  output logic                          pready
);

  sqsab_pkg::uword_t     uword;
  sqsab_pkg::dp_status_t status;
  sqsab_pkg::cfg_t       cfg_q;
  logic                  in_fire, cfg_wr;
  logic [1:0]            reg_idx;

  assign s_axis_tready = (uword.act == sqsab_pkg::ACT_CAPTURE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit   <= sqsab_pkg::LOW_LIMIT_RST;
      cfg_q.high_limit  <= sqsab_pkg::HIGH_LIMIT_RST;
      cfg_q.threshold   <= sqsab_pkg::THRESHOLD_RST;
      cfg_q.slow_period <= sqsab_pkg::SLOW_PER_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sqsab_pkg::REG_LOW_LIMIT:  cfg_q.low_limit   <= pwdata[9:0];
        sqsab_pkg::REG_HIGH_LIMIT: cfg_q.high_limit  <= pwdata[9:0];
        sqsab_pkg::REG_THRESHOLD:  cfg_q.threshold   <= pwdata[9:0];
        sqsab_pkg::REG_SLOW_PER:   cfg_q.slow_period <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      sqsab_pkg::REG_LOW_LIMIT:  prdata = {22'd0, cfg_q.low_limit};
      sqsab_pkg::REG_HIGH_LIMIT: prdata = {22'd0, cfg_q.high_limit};
      sqsab_pkg::REG_THRESHOLD:  prdata = {22'd0, cfg_q.threshold};
      sqsab_pkg::REG_SLOW_PER:   prdata = {29'd0, cfg_q.slow_period};
      default:                   prdata = '0;
    endcase
  end

  sqsab_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uword_o  (uword)
  );

  sqsab_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uword_i     (uword),
    .cfg_i       (cfg_q),
    .in_fire_i   (in_fire),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
